FILE: sv/vap_pkg.sv
// Shared types and constants for the valve angle positioner.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package vap_pkg;

  // item opcode
  typedef enum logic [1:0] {
    KIND_ANGLE   = 2'd0,
    KIND_PERCENT = 2'd1,
    KIND_SAMPLE  = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  // direction request of a move command
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_CW    = 2'd1,
    MODE_CCW   = 2'd2,
    MODE_SHORT = 2'd3
  } mode_t;

  // motor drive
  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_CW   = 2'd1,
    DRIVE_CCW  = 2'd2
  } drive_t;

  typedef struct packed {
    kind_t kind;
    mode_t mode;
  } cmd_t;

  // opening classification of the query path
  typedef struct packed {
    logic full;    // far side of base, reads fully open
    logic closed;  // more than a quarter turn short of base
  } open_flags_t;

  localparam int CFG_W = 12;
  localparam int ANG_IN_W = 12;
  localparam int REQ_W = 16;
  localparam int PCT_W = 10;
  localparam int IDX_W = 2;

  localparam logic [PCT_W-1:0] PCT_MAX = 10'd1000;
  localparam int PCT_HALF = 500;
  localparam int PCT_SCALE = 1000;

  localparam logic [IDX_W-1:0] REG_BASE = 2'd0;
  localparam logic [IDX_W-1:0] REG_TOL  = 2'd1;
  localparam logic [IDX_W-1:0] REG_LEAD = 2'd2;

  localparam logic [CFG_W-1:0] TOL_RESET  = 12'd10;
  localparam logic [CFG_W-1:0] LEAD_RESET = 12'd10;

endpackage

`default_nettype wire

FILE: sv/vap_prep.sv
// Input stage: reduces the angle fields modulo one turn and forms the
// rounded numerator of the percent-to-angle offset. Uses vap_pkg.
`default_nettype none

module vap_prep #(
  parameter int ANGLE_STEPS = 3600,
  localparam int AW = $clog2(ANGLE_STEPS),
  localparam int Q = ANGLE_STEPS / 4,
  localparam int TW = $clog2(vap_pkg::PCT_SCALE * Q + vap_pkg::PCT_HALF + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [1:0]                          in_mode,
  input  wire logic [vap_pkg::ANG_IN_W-1:0]        in_target_angle,
  input  wire logic signed [vap_pkg::REQ_W-1:0]    in_open_request,
  input  wire logic [vap_pkg::ANG_IN_W-1:0]        in_sensor_angle,
  input  wire logic [vap_pkg::CFG_W-1:0]           base_angle,
  output vap_pkg::cmd_t                            cmd_r,
  output logic [AW-1:0]                            target_r,
  output logic [AW-1:0]                            sensor_r,
  output logic [AW-1:0]                            base_r,
  output logic [TW-1:0]                            numer_r
);

  localparam int XW = (AW > vap_pkg::ANG_IN_W) ? AW : vap_pkg::ANG_IN_W;
  localparam int KMAX = ((1 << vap_pkg::ANG_IN_W) - 1) / ANGLE_STEPS;

  // at most a handful of turns fit in 12 bits: parallel compares, pick largest
  function automatic logic [AW-1:0] wrap_angle(input logic [vap_pkg::ANG_IN_W-1:0] x);
    logic [XW-1:0] xe;
    logic [XW-1:0] r;
    xe = XW'(x);
    r = xe;
    for (int k = 1; k <= KMAX; k++) begin
      if (xe >= XW'(k * ANGLE_STEPS)) r = xe - XW'(k * ANGLE_STEPS);
    end
    return r[AW-1:0];
  endfunction

  logic [vap_pkg::PCT_W-1:0] pct_c;
  logic [vap_pkg::PCT_W-1:0] closing;
  logic [TW-1:0]             numer_nxt;

  always_comb begin
    if (in_open_request[vap_pkg::REQ_W-1]) begin
      pct_c = '0;
    end else if (in_open_request > vap_pkg::REQ_W'(signed'(vap_pkg::PCT_SCALE))) begin
      pct_c = vap_pkg::PCT_MAX;
    end else begin
      pct_c = in_open_request[vap_pkg::PCT_W-1:0];
    end
    closing = vap_pkg::PCT_MAX - pct_c;
    numer_nxt = TW'(closing) * TW'(Q) + TW'(vap_pkg::PCT_HALF);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r.kind <= vap_pkg::kind_t'(in_kind);
      cmd_r.mode <= vap_pkg::mode_t'(in_mode);
      target_r   <= wrap_angle(in_target_angle);
      sensor_r   <= wrap_angle(in_sensor_angle);
      base_r     <= wrap_angle(base_angle);
      numer_r    <= numer_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/vap_target.sv
// Second stage: percent target angle (offset below base) and the opening
// numerator for queries. Uses vap_pkg.
`default_nettype none

module vap_target #(
  parameter int ANGLE_STEPS = 3600,
  localparam int AW = $clog2(ANGLE_STEPS),
  localparam int Q = ANGLE_STEPS / 4,
  localparam int QW = $clog2(Q + 1),
  localparam int TW = $clog2(vap_pkg::PCT_SCALE * Q + vap_pkg::PCT_HALF + 1),
  localparam int UW = $clog2(vap_pkg::PCT_SCALE * Q + Q / 2 + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 load,
  input  wire vap_pkg::cmd_t        cmd_a,
  input  wire logic [AW-1:0]        target_a,
  input  wire logic [AW-1:0]        sensor_a,
  input  wire logic [AW-1:0]        base_a,
  input  wire logic [TW-1:0]        numer_a,
  output vap_pkg::cmd_t             cmd_r,
  output logic [AW-1:0]             target_r,
  output logic [AW-1:0]             sensor_r,
  output logic [UW-1:0]             numer_r,
  output vap_pkg::open_flags_t      flags_r
);

  // exact floor division by 1000: numerator below 2^TW, ceil reciprocal
  localparam int K1 = TW + $clog2(vap_pkg::PCT_SCALE);
  localparam longint unsigned M1 =
      ((64'd1 << K1) + longint'(vap_pkg::PCT_SCALE) - 64'd1) / vap_pkg::PCT_SCALE;
  localparam int PW1 = TW + TW + 1;

  function automatic logic [AW-1:0] dist_cw(input logic [AW-1:0] to,
                                            input logic [AW-1:0] from);
    logic [AW:0] s;
    if (to >= from) s = {1'b0, to} - {1'b0, from};
    else s = {1'b0, to} + (AW+1)'(ANGLE_STEPS) - {1'b0, from};
    return s[AW-1:0];
  endfunction

  logic [PW1-1:0]  prod1;
  logic [QW-1:0]   offset;
  logic [AW:0]     pct_tgt;
  logic [AW-1:0]   cw_to_base;
  logic [QW-1:0]   short_by;
  vap_pkg::cmd_t   cmd_nxt;
  logic [AW-1:0]   target_nxt;
  vap_pkg::open_flags_t flags_nxt;

  always_comb begin
    prod1 = PW1'(numer_a) * PW1'(M1);
    offset = prod1[K1 +: QW];
    if (base_a >= AW'(offset)) pct_tgt = {1'b0, base_a} - (AW+1)'(offset);
    else pct_tgt = {1'b0, base_a} + (AW+1)'(ANGLE_STEPS) - (AW+1)'(offset);

    cmd_nxt = cmd_a;
    target_nxt = target_a;
    if (cmd_a.kind == vap_pkg::KIND_PERCENT) begin
      cmd_nxt.mode = vap_pkg::MODE_SHORT;
      target_nxt = pct_tgt[AW-1:0];
    end

    cw_to_base = dist_cw(base_a, sensor_a);
    flags_nxt.full = ({1'b0, cw_to_base} > (AW+1)'(3 * Q));
    flags_nxt.closed = (cw_to_base > AW'(Q));
    short_by = (cw_to_base > AW'(Q)) ? '0 : QW'(AW'(Q) - cw_to_base);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r    <= cmd_nxt;
      target_r <= target_nxt;
      sensor_r <= sensor_a;
      numer_r  <= UW'(short_by) * UW'(vap_pkg::PCT_SCALE) + UW'(Q / 2);
      flags_r  <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/vap_core.sv
// Result stage: move state (direction, start, goal), completion check,
// opening scale and the result register. Uses vap_pkg.
`default_nettype none

module vap_core #(
  parameter int ANGLE_STEPS = 3600,
  localparam int AW = $clog2(ANGLE_STEPS),
  localparam int Q = ANGLE_STEPS / 4,
  localparam int UW = $clog2(vap_pkg::PCT_SCALE * Q + Q / 2 + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire vap_pkg::cmd_t              cmd_b,
  input  wire logic [AW-1:0]              target_b,
  input  wire logic [AW-1:0]              sensor_b,
  input  wire logic [UW-1:0]              numer_b,
  input  wire vap_pkg::open_flags_t       flags_b,
  input  wire logic [vap_pkg::CFG_W-1:0]  stop_tolerance,
  input  wire logic [vap_pkg::CFG_W-1:0]  early_stop,
  output vap_pkg::drive_t                 drive_r,
  output logic                            finished_r,
  output logic [vap_pkg::PCT_W-1:0]       pct_r,
  output logic                            rejected_r
);

  localparam int CW = (AW > vap_pkg::CFG_W) ? AW : vap_pkg::CFG_W;
  // exact floor division by the quarter turn
  localparam int K2 = UW + $clog2(Q);
  localparam longint unsigned M2 = ((64'd1 << K2) + longint'(Q) - 64'd1) / Q;
  localparam int PW2 = UW + UW + 1;

  function automatic logic [AW-1:0] dist_cw(input logic [AW-1:0] to,
                                            input logic [AW-1:0] from);
    logic [AW:0] s;
    if (to >= from) s = {1'b0, to} - {1'b0, from};
    else s = {1'b0, to} + (AW+1)'(ANGLE_STEPS) - {1'b0, from};
    return s[AW-1:0];
  endfunction

  vap_pkg::drive_t run_r, run_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [AW-1:0]   goal_r, goal_nxt;

  vap_pkg::drive_t dir;
  logic            dir_ok;
  logic [AW-1:0]   d_cw, d_ccw, trip, moved;
  logic [CW-1:0]   trip_less_lead;
  logic [PW2-1:0]  prod2;
  logic            fin, rej;
  logic [vap_pkg::PCT_W-1:0] pct;

  always_comb begin
    run_nxt = run_r;
    start_nxt = start_r;
    goal_nxt = goal_r;
    fin = 1'b0;
    rej = 1'b0;
    pct = '0;

    d_cw = dist_cw(target_b, sensor_b);
    d_ccw = dist_cw(sensor_b, target_b);
    dir = vap_pkg::DRIVE_STOP;
    dir_ok = 1'b0;
    case (cmd_b.mode)
      vap_pkg::MODE_CW: begin
        dir = vap_pkg::DRIVE_CW;
        dir_ok = 1'b1;
      end
      vap_pkg::MODE_CCW: begin
        dir = vap_pkg::DRIVE_CCW;
        dir_ok = 1'b1;
      end
      vap_pkg::MODE_SHORT: begin
        // a tie goes counterclockwise
        dir = (d_cw < d_ccw) ? vap_pkg::DRIVE_CW : vap_pkg::DRIVE_CCW;
        dir_ok = 1'b1;
      end
      default: ;
    endcase
    trip = (dir == vap_pkg::DRIVE_CW) ? d_cw : d_ccw;
    trip_less_lead = CW'(trip) - CW'(early_stop);
    moved = (run_r == vap_pkg::DRIVE_CW) ? dist_cw(sensor_b, start_r)
                                         : dist_cw(start_r, sensor_b);
    prod2 = PW2'(numer_b) * PW2'(M2);

    case (cmd_b.kind)
      vap_pkg::KIND_ANGLE, vap_pkg::KIND_PERCENT: begin
        if (run_r != vap_pkg::DRIVE_STOP) begin
          rej = 1'b1;
        end else if (dir_ok) begin
          if (CW'(trip) <= CW'(stop_tolerance)) begin
            fin = 1'b1;
          end else begin
            run_nxt = dir;
            start_nxt = sensor_b;
            goal_nxt = (CW'(trip) > CW'(early_stop)) ? trip_less_lead[AW-1:0] : '0;
          end
        end
      end
      vap_pkg::KIND_SAMPLE: begin
        if (run_r != vap_pkg::DRIVE_STOP && moved >= goal_r) begin
          run_nxt = vap_pkg::DRIVE_STOP;
          fin = 1'b1;
        end
      end
      vap_pkg::KIND_QUERY: begin
        if (flags_b.full) pct = vap_pkg::PCT_MAX;
        else if (flags_b.closed) pct = '0;
        else pct = prod2[K2 +: vap_pkg::PCT_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= vap_pkg::DRIVE_STOP;
      start_r <= '0;
      goal_r  <= '0;
    end else if (load) begin
      run_r   <= run_nxt;
      start_r <= start_nxt;
      goal_r  <= goal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r    <= run_nxt;
      finished_r <= fin;
      pct_r      <= pct;
      rejected_r <= rej;
    end
  end

endmodule

`default_nettype wire

FILE: sv/valve_angle_positioner.sv
// Top level of the valve angle positioner: configuration registers,
// pipeline flow control and the three stages. Uses vap_pkg, vap_prep,
// vap_target and vap_core.
//
// One item per clock sustained while out_stall is low; each item passes through
// the input stage, the target stage and then the result register, and is
// delayed beyond that only while the result side stalls; with all three stages
// full, in_stall follows out_stall in the same cycle. The move state is
// updated in the result stage alone, so a command depends on the item just
// before it without a bubble. Angles are in steps of ANGLE_STEPS per turn; a
// percent command targets base minus a quarter turn scaled by the closing
// amount, and a query reports the opening in tenths of a percent.
// The user writes configuration through the cfg port, which is always ready,
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module valve_angle_positioner #(
  parameter int ANGLE_STEPS = 3600
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_kind,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [vap_pkg::ANG_IN_W-1:0]      in_target_angle,
  input  wire logic signed [vap_pkg::REQ_W-1:0]  in_open_request,
  input  wire logic [vap_pkg::ANG_IN_W-1:0]      in_sensor_angle,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_drive,
  output logic                                   out_finished,
  output logic [vap_pkg::PCT_W-1:0]              out_open_percent,
  output logic                                   out_rejected,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vap_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [vap_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(ANGLE_STEPS);
  localparam int Q = ANGLE_STEPS / 4;
  localparam int TW = $clog2(vap_pkg::PCT_SCALE * Q + vap_pkg::PCT_HALF + 1);
  localparam int UW = $clog2(vap_pkg::PCT_SCALE * Q + Q / 2 + 1);

  logic [vap_pkg::CFG_W-1:0] base_r, tol_r, lead_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      tol_r  <= vap_pkg::TOL_RESET;
      lead_r <= vap_pkg::LEAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vap_pkg::REG_BASE: base_r <= cfg_data;
        vap_pkg::REG_TOL:  tol_r  <= cfg_data;
        vap_pkg::REG_LEAD: lead_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control: a stage loads when it is empty or its content moves on
  logic a_valid_r, b_valid_r, o_valid_r;
  logic o_rdy, b_rdy, a_rdy;
  logic a_load, b_load, o_load;

  assign o_rdy  = !o_valid_r || !out_stall;
  assign b_rdy  = !b_valid_r || o_rdy;
  assign a_rdy  = !a_valid_r || b_rdy;
  assign a_load = in_valid && a_rdy;
  assign b_load = a_valid_r && b_rdy;
  assign o_load = b_valid_r && o_rdy;

  assign in_stall  = !a_rdy;
  assign out_valid = o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_rdy) a_valid_r <= in_valid;
      if (b_rdy) b_valid_r <= a_valid_r;
      if (o_rdy) o_valid_r <= b_valid_r;
    end
  end

  vap_pkg::cmd_t        cmd_a, cmd_b;
  logic [AW-1:0]        target_a, sensor_a, base_a;
  logic [TW-1:0]        numer_a;
  logic [AW-1:0]        target_b, sensor_b;
  logic [UW-1:0]        numer_b;
  vap_pkg::open_flags_t flags_b;
  vap_pkg::drive_t      drive_o;

  vap_prep #(.ANGLE_STEPS(ANGLE_STEPS)) u_prep (
    .clk             (clk),
    .load            (a_load),
    .in_kind         (in_kind),
    .in_mode         (in_mode),
    .in_target_angle (in_target_angle),
    .in_open_request (in_open_request),
    .in_sensor_angle (in_sensor_angle),
    .base_angle      (base_r),
    .cmd_r           (cmd_a),
    .target_r        (target_a),
    .sensor_r        (sensor_a),
    .base_r          (base_a),
    .numer_r         (numer_a)
  );

  vap_target #(.ANGLE_STEPS(ANGLE_STEPS)) u_target (
    .clk      (clk),
    .load     (b_load),
    .cmd_a    (cmd_a),
    .target_a (target_a),
    .sensor_a (sensor_a),
    .base_a   (base_a),
    .numer_a  (numer_a),
    .cmd_r    (cmd_b),
    .target_r (target_b),
    .sensor_r (sensor_b),
    .numer_r  (numer_b),
    .flags_r  (flags_b)
  );

  vap_core #(.ANGLE_STEPS(ANGLE_STEPS)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (o_load),
    .cmd_b          (cmd_b),
    .target_b       (target_b),
    .sensor_b       (sensor_b),
    .numer_b        (numer_b),
    .flags_b        (flags_b),
    .stop_tolerance (tol_r),
    .early_stop     (lead_r),
    .drive_r        (drive_o),
    .finished_r     (out_finished),
    .pct_r          (out_open_percent),
    .rejected_r     (out_rejected)
  );

  assign out_drive = drive_o;

endmodule

`default_nettype wire

FILE: sv/vap_checker.sv
// Port-level checks for the valve angle positioner, bound to the top level.
// Depends on vap_pkg and valve_angle_positioner.
`default_nettype none

module vap_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        out_drive,
  input wire logic                              out_finished,
  input wire logic [vap_pkg::PCT_W-1:0]         out_open_percent,
  input wire logic                              out_rejected
);

  // a rejected command leaves the running move in place
  a_reject_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_drive != vap_pkg::DRIVE_STOP)
    else $error("rejected item while drive stopped");

  // finishing, by skip or by completion, always leaves the motor stopped
  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_drive == vap_pkg::DRIVE_STOP && !out_rejected)
    else $error("finished item with drive running");

  // only a query carries an opening, and it never exceeds full scale
  a_pct_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_open_percent != '0 |->
      !out_finished && !out_rejected && out_open_percent <= vap_pkg::PCT_MAX)
    else $error("opening reported on a non-query item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive) &&
      $stable(out_finished) && $stable(out_open_percent) && $stable(out_rejected))
    else $error("stalled result changed");

endmodule

bind valve_angle_positioner vap_checker u_vap_checker (.*);

`default_nettype wire

FILE: test/valve_angle_positioner_tb.sv
`timescale 1ns / 100ps
// Testbench for valve_angle_positioner: directed and random command streams under
// random stalls, each result checked against a behavioral model of the move logic.
// Depends on vap_pkg and the valve_angle_positioner RTL.

module valve_angle_positioner_tb;

  localparam int STEPS = 3600;
  localparam int QTR = STEPS / 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_TARGET = 1200;
  localparam int SETTINGS_RUN = 7;
  localparam int MAX_SHOWN = 10;
  localparam int AIW = vap_pkg::ANG_IN_W;
  localparam int RQW = vap_pkg::REQ_W;
  localparam int CFW = vap_pkg::CFG_W;

  typedef struct packed {
    vap_pkg::kind_t kind;
    vap_pkg::mode_t mode;
    logic [AIW-1:0] target;
    logic signed [RQW-1:0] request;
    logic [AIW-1:0] sensor;
  } valve_cmd_t;

  typedef struct packed {
    vap_pkg::drive_t drive;
    logic finished;
    logic [vap_pkg::PCT_W-1:0] pct;
    logic rejected;
  } valve_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [1:0] in_mode = '0;
  logic [AIW-1:0] in_target_angle = '0;
  logic signed [RQW-1:0] in_open_request = '0;
  logic [AIW-1:0] in_sensor_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_drive;
  logic out_finished;
  logic [vap_pkg::PCT_W-1:0] out_open_percent;
  logic out_rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vap_pkg::IDX_W-1:0] cfg_index = '0;
  logic [CFW-1:0] cfg_data = '0;

  // model copy of registers and move state
  int unsigned reg_base = 0;
  int unsigned reg_tol = 32'(vap_pkg::TOL_RESET);
  int unsigned reg_lead = 32'(vap_pkg::LEAD_RESET);
  vap_pkg::drive_t run_dir = vap_pkg::DRIVE_STOP;
  int unsigned run_start = 0;
  int unsigned run_goal = 0;

  valve_res_t pending_results[$];

  int sent_items = 0;
  int results_seen = 0;
  int moves_finished = 0;
  int refusals = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int unsigned plant_pos = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  valve_angle_positioner #(.ANGLE_STEPS(STEPS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_mode(in_mode),
    .in_target_angle(in_target_angle),
    .in_open_request(in_open_request),
    .in_sensor_angle(in_sensor_angle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive),
    .out_finished(out_finished),
    .out_open_percent(out_open_percent),
    .out_rejected(out_rejected),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic int unsigned wrap_steps(int unsigned a);
    return a % STEPS;
  endfunction

  function automatic int unsigned cw_span(int unsigned to_a, int unsigned from_a);
    return (to_a >= from_a) ? to_a - from_a : to_a + STEPS - from_a;
  endfunction

  function automatic int unsigned span_along(vap_pkg::drive_t d, int unsigned to_a,
                                             int unsigned from_a);
    return (d == vap_pkg::DRIVE_CW) ? cw_span(to_a, from_a) : cw_span(from_a, to_a);
  endfunction

  function automatic vap_pkg::drive_t heading(vap_pkg::mode_t m, int unsigned to_a,
                                              int unsigned from_a);
    if (m == vap_pkg::MODE_CW) return vap_pkg::DRIVE_CW;
    if (m == vap_pkg::MODE_CCW) return vap_pkg::DRIVE_CCW;
    // shorter way; a tie turns counterclockwise
    return (cw_span(to_a, from_a) < cw_span(from_a, to_a)) ? vap_pkg::DRIVE_CW
                                                           : vap_pkg::DRIVE_CCW;
  endfunction

  function automatic int unsigned percent_target(logic signed [RQW-1:0] req);
    int unsigned p, off, b;
    if (req[RQW-1]) p = 0;
    else if (req > 16'sd1000) p = vap_pkg::PCT_SCALE;
    else p = 32'(req);
    off = ((vap_pkg::PCT_SCALE - p) * QTR + vap_pkg::PCT_HALF) / vap_pkg::PCT_SCALE;
    b = wrap_steps(reg_base);
    return (b >= off) ? b - off : b + STEPS - off;
  endfunction

  // returns 1 when the valve is already within tolerance
  function automatic logic begin_move(vap_pkg::mode_t m, int unsigned to_a,
                                      int unsigned from_a);
    vap_pkg::drive_t d;
    int unsigned span;
    if (m == vap_pkg::MODE_NONE) return 1'b0;
    d = heading(m, to_a, from_a);
    span = span_along(d, to_a, from_a);
    if (span <= reg_tol) return 1'b1;
    run_dir = d;
    run_start = from_a;
    run_goal = (span > reg_lead) ? span - reg_lead : 0;
    return 1'b0;
  endfunction

  function automatic logic [vap_pkg::PCT_W-1:0] opening_at(int unsigned cur);
    int unsigned c;
    c = cw_span(wrap_steps(reg_base), cur);
    if (c > 3 * QTR) return vap_pkg::PCT_MAX;
    if (c > QTR) return '0;
    return vap_pkg::PCT_W'(((QTR - c) * vap_pkg::PCT_SCALE + QTR / 2) / QTR);
  endfunction

  function automatic valve_res_t valve_response(valve_cmd_t c);
    valve_res_t r;
    int unsigned sens;
    r.drive = vap_pkg::DRIVE_STOP;
    r.finished = 1'b0;
    r.pct = '0;
    r.rejected = 1'b0;
    sens = wrap_steps(32'(c.sensor));
    case (c.kind)
      vap_pkg::KIND_ANGLE, vap_pkg::KIND_PERCENT: begin
        if (run_dir != vap_pkg::DRIVE_STOP) r.rejected = 1'b1;
        else if (c.kind == vap_pkg::KIND_ANGLE)
          r.finished = begin_move(c.mode, wrap_steps(32'(c.target)), sens);
        else r.finished = begin_move(vap_pkg::MODE_SHORT, percent_target(c.request), sens);
      end
      vap_pkg::KIND_SAMPLE: begin
        if (run_dir != vap_pkg::DRIVE_STOP &&
            span_along(run_dir, sens, run_start) >= run_goal) begin
          run_dir = vap_pkg::DRIVE_STOP;
          r.finished = 1'b1;
        end
      end
      default: r.pct = opening_at(sens);
    endcase
    r.drive = run_dir;
    return r;
  endfunction

  // results are checked before the item of the same edge is predicted
  always @(posedge clk) begin : monitor
    valve_cmd_t c;
    valve_res_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.drive = vap_pkg::drive_t'(out_drive);
        got.finished = out_finished;
        got.pct = out_open_percent;
        got.rejected = out_rejected;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d arrived with nothing outstanding", results_seen);
        end else begin
          want = pending_results.pop_front();
          if (got.drive !== want.drive || got.finished !== want.finished ||
              got.pct !== want.pct || got.rejected !== want.rejected) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("result %0d: expected drive %0d fin %0b open %0d rej %0b, %s%0d %s%0b %s%0d %s%0b",
                       results_seen, want.drive, want.finished, want.pct, want.rejected,
                       "got drive ", got.drive, "fin ", got.finished,
                       "open ", got.pct, "rej ", got.rejected);
          end
        end
      end
      if (in_valid && !in_stall) begin
        c.kind = vap_pkg::kind_t'(in_kind);
        c.mode = vap_pkg::mode_t'(in_mode);
        c.target = in_target_angle;
        c.request = in_open_request;
        c.sensor = in_sensor_angle;
        want = valve_response(c);
        moves_finished += want.finished;
        refusals += want.rejected;
        pending_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          vap_pkg::REG_BASE: reg_base = 32'(cfg_data);
          vap_pkg::REG_TOL:  reg_tol = 32'(cfg_data);
          vap_pkg::REG_LEAD: reg_lead = 32'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [AIW-1:0] rnd_angle();
    return AIW'($urandom);
  endfunction

  function automatic logic signed [RQW-1:0] rnd_req();
    return RQW'($urandom);
  endfunction

  function automatic vap_pkg::mode_t rnd_mode();
    return vap_pkg::mode_t'($urandom_range(0, 3));
  endfunction

  // result side stall pattern; rx_hold forces one long hold-off
  initial begin : result_sink
    int stall_left, free_left;
    stall_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
        else begin
          free_left = $urandom_range(0, 8);
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else idle++;
    end
    $display("no handshake for %0d cycles", IDLE_LIMIT);
    $display("[valve_angle_positioner] ERROR");
    $finish;
  end

  task automatic send_item(vap_pkg::kind_t k, vap_pkg::mode_t m, logic [AIW-1:0] tgt,
                           logic signed [RQW-1:0] req, logic [AIW-1:0] sens);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= k;
    in_mode <= m;
    in_target_angle <= tgt;
    in_open_request <= req;
    in_sensor_angle <= sens;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_items++;
  endtask

  // drop valid and wait for the pipeline to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [vap_pkg::IDX_W-1:0] idx, logic [CFW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [CFW-1:0] base, logic [CFW-1:0] tol,
                           logic [CFW-1:0] lead);
    settle();
    write_reg(vap_pkg::REG_BASE, base);
    write_reg(vap_pkg::REG_TOL, tol);
    write_reg(vap_pkg::REG_LEAD, lead);
  endtask

  // low readings may also show up one turn higher, in the unwrapped range
  function automatic logic [AIW-1:0] sensor_word(int unsigned pos);
    if (pos < (1 << AIW) - STEPS && $urandom_range(0, 7) == 0) return AIW'(pos + STEPS);
    return AIW'(pos);
  endfunction

  task automatic noise_item();
    send_item(vap_pkg::kind_t'($urandom_range(0, 3)), rnd_mode(),
              rnd_angle(), rnd_req(), rnd_angle());
  endtask

  // one command, then a sensor sweep toward and past its target
  task automatic move_episode();
    vap_pkg::kind_t k;
    vap_pkg::mode_t m;
    logic [AIW-1:0] tgt_word;
    logic signed [RQW-1:0] req;
    int unsigned tgt, span, travel, reach, hop, hop_max;
    vap_pkg::drive_t d;
    req = rnd_req();
    tgt_word = rnd_angle();
    if ($urandom_range(0, 2) == 0) begin
      k = vap_pkg::KIND_PERCENT;
      m = rnd_mode();
      case ($urandom_range(0, 4))
        0: req = rnd_req();
        1: req = -RQW'($urandom_range(1, 50));
        2: req = RQW'($urandom_range(1001, 1100));
        default: req = RQW'($urandom_range(0, 1000));
      endcase
      tgt = percent_target(req);
      d = heading(vap_pkg::MODE_SHORT, tgt, plant_pos);
    end else begin
      k = vap_pkg::KIND_ANGLE;
      m = vap_pkg::mode_t'($urandom_range(1, 3));
      if ($urandom_range(0, 19) == 0) m = vap_pkg::MODE_NONE;
      tgt_word = ($urandom_range(0, 9) == 0) ? AIW'($urandom_range(STEPS, 4095))
                                               : AIW'($urandom_range(0, STEPS - 1));
      tgt = wrap_steps(32'(tgt_word));
      d = heading(m, tgt, plant_pos);
    end
    span = span_along(d, tgt, plant_pos);
    send_item(k, m, tgt_word, req, sensor_word(plant_pos));
    hop_max = span / 6 + 2;
    reach = span + $urandom_range(0, 30);
    travel = 0;
    while (travel < reach) begin
      hop = $urandom_range(1, hop_max);
      travel += hop;
      plant_pos = (d == vap_pkg::DRIVE_CW) ? wrap_steps(plant_pos + hop)
                                           : wrap_steps(plant_pos + STEPS - hop);
      send_item(vap_pkg::KIND_SAMPLE, rnd_mode(), rnd_angle(), rnd_req(),
                sensor_word(plant_pos));
      case ($urandom_range(0, 15))
        0: send_item(vap_pkg::KIND_QUERY, rnd_mode(), rnd_angle(), rnd_req(),
                     sensor_word(plant_pos));
        1: send_item(vap_pkg::KIND_ANGLE, vap_pkg::mode_t'($urandom_range(1, 3)),
                     AIW'($urandom_range(0, STEPS - 1)), rnd_req(),
                     sensor_word(plant_pos));
        2: send_item(vap_pkg::KIND_PERCENT, rnd_mode(), rnd_angle(), rnd_req(),
                     sensor_word(plant_pos));
        3: send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, rnd_angle(), rnd_req(),
                     rnd_angle());  // glitch
        default: ;
      endcase
    end
  endtask

  task automatic test_directed();
    // openings: at base, quarter turn either side, just short of base, unwrapped reading
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd0);
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd900);
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd2700);
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd3599);
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'hFFF);
    // no direction: ignored
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_NONE, 12'd500, 16'sd0, 12'd0);
    // inside tolerance, then right at it
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_CW, 12'd5, 16'sd0, 12'd0);
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_CW, 12'd10, 16'sd0, 12'd0);
    // stopped: no effect
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd20);
    // goal 90
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_CW, 12'd100, 16'sd0, 12'd0);
    // refused while running
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_CCW, 12'd3000, 16'sd0, 12'd40);
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_NONE, 12'd0, 16'sd500, 12'd40);
    send_item(vap_pkg::KIND_QUERY, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd40);
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd89);
    // travel equals goal
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd90);
    // target wraps
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_CCW, 12'hFFF, 16'sd0, 12'd90);
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd505);
    // half turn tie
    send_item(vap_pkg::KIND_ANGLE, vap_pkg::MODE_SHORT, 12'd2305, 16'sd0, 12'd505);
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd2315);
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_NONE, 12'd0, 16'sh8000, 12'd2315);
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd2690);
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_SHORT, 12'hFFF, 16'sd32767, 12'd0);
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_NONE, 12'd0, 16'sd1000, 12'd3600);
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd2700);
    // tie, runs ccw
    send_item(vap_pkg::KIND_PERCENT, vap_pkg::MODE_NONE, 12'd0, 16'sd1001, 12'd1800);
    send_item(vap_pkg::KIND_SAMPLE, vap_pkg::MODE_NONE, 12'd0, 16'sd0, 12'd10);
    plant_pos = 10;
  endtask

  task automatic test_backpressure();
    int start;
    settle();
    rx_hold = 150;
    tx_quiet = 1'b1;
    start = sent_items;
    while (sent_items - start < 40) move_episode();
    tx_quiet = 1'b0;
    settle();
  endtask

  task automatic test_random_settings();
    int start, r;
    for (int s = 0; s < SETTINGS_RUN; s++) begin
      case (s)
        0: configure(12'd0, 12'd0, 12'd0);
        1: configure(12'hFFF, 12'hFFF, 12'hFFF);
        2: configure(12'd3599, 12'd0, 12'd3599);
        3: configure(CFW'(STEPS / 2), 12'd3599, 12'd0);
        default: configure(CFW'($urandom_range(0, 4095)), CFW'($urandom_range(0, 40)),
                           CFW'($urandom_range(0, 40)));
      endcase
      tx_quiet = (s == 4);
      rx_quiet = (s == 4);
      start = sent_items;
      while (sent_items - start < ITEM_TARGET / SETTINGS_RUN) begin
        r = $urandom_range(0, 19);
        if (r == 0) settle();
        else if (r < 4) noise_item();
        else move_episode();
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_settings();
    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d items over %0d register writes and got %0d results back;",
             sent_items, reg_writes, results_seen);
    $display("%0d moves finished or skipped, %0d commands refused mid-move, %0d mismatches.",
             moves_finished, refusals, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[valve_angle_positioner] OK");
    end else begin
      $display("[valve_angle_positioner] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/vap_pkg.sv
sv/vap_prep.sv
sv/vap_target.sv
sv/vap_core.sv
sv/valve_angle_positioner.sv
sv/vap_checker.sv
test/valve_angle_positioner_tb.sv
